>>> rtl/core/mms_pkg.sv
// ============================================================================
// Mower mode supervisor package
// Shared mode and event codes, register layout, state and result types, and
// the transition functions used by the next-state logic.
// ============================================================================
package mms_pkg;

  localparam int TIME_WIDTH = 24;
  localparam int CFG_WIDTH  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CMP_W      = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  typedef logic [2:0]            mode_t;
  typedef logic [3:0]            event_t;
  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // Mode codes.
  localparam mode_t MODE_IDLE   = 3'd0;
  localparam mode_t MODE_MOW    = 3'd1;
  localparam mode_t MODE_MANUAL = 3'd2;
  localparam mode_t MODE_RETURN = 3'd3;
  localparam mode_t MODE_CHARGE = 3'd4;
  localparam mode_t MODE_EMERG  = 3'd5;
  localparam mode_t MODE_BORDER = 3'd6;
  localparam mode_t MODE_OBST   = 3'd7;

  // Event codes.
  localparam event_t EV_START    = 4'd0;
  localparam event_t EV_STOP     = 4'd1;
  localparam event_t EV_MANUAL   = 4'd2;
  localparam event_t EV_RETURN   = 4'd3;
  localparam event_t EV_LOWBAT   = 4'd4;
  localparam event_t EV_CHARGED  = 4'd5;
  localparam event_t EV_OBST     = 4'd6;
  localparam event_t EV_BORDER   = 4'd7;
  localparam event_t EV_ERROR    = 4'd8;
  localparam event_t EV_RESOLVED = 4'd9;
  localparam event_t EV_ESTOP    = 4'd10;
  localparam event_t EV_CLEARED  = 4'd11;
  localparam event_t EV_DOCKED   = 4'd12;

  // Register indexes.
  localparam cfg_idx_t CFG_MOW_LIMIT    = 2'd0;
  localparam cfg_idx_t CFG_OBST_TIMEOUT = 2'd1;
  localparam cfg_idx_t CFG_BORD_TIMEOUT = 2'd2;

  localparam cfg_word_t MOW_LIMIT_RESET    = CFG_WIDTH'(30 * 60 * 1000);
  localparam cfg_word_t OBST_TIMEOUT_RESET = CFG_WIDTH'(10000);
  localparam cfg_word_t BORD_TIMEOUT_RESET = CFG_WIDTH'(5000);

  typedef struct packed {
    cfg_word_t mow_limit;
    cfg_word_t obst_timeout;
    cfg_word_t bord_timeout;
  } cfg_t;

  typedef struct packed {
    mode_t cur;
    mode_t prior;
    time_t elapsed;
    logic  blade;
    logic  wander;
  } sv_state_t;

  // Working copy of the state while one request is evaluated.
  typedef struct packed {
    sv_state_t st;
    logic      changed;
  } step_t;

  typedef struct packed {
    mode_t mode_now;
    logic  mode_changed;
    logic  relay_enable;
    logic  blade_enable;
    logic  nav_random;
  } result_t;

  function automatic logic over(time_t elapsed, cfg_word_t limit);
    return CMP_W'(elapsed) > CMP_W'(limit);
  endfunction

  function automatic step_t go_to(step_t s, mode_t next);
    step_t r;
    r = s;
    if (next != s.st.cur) begin
      r.st.prior   = s.st.cur;
      r.st.cur     = next;
      r.st.elapsed = '0;
      r.changed    = 1'b1;
      case (next)
        MODE_MOW: begin
          r.st.wander = 1'b1;
          r.st.blade  = 1'b1;
        end
        MODE_IDLE, MODE_RETURN, MODE_CHARGE, MODE_EMERG: begin
          r.st.wander = 1'b0;
          r.st.blade  = 1'b0;
        end
        MODE_BORDER, MODE_OBST: begin
          r.st.wander = 1'b0;
        end
        default: begin
          r.st.wander = r.st.wander;
        end
      endcase
    end
    return r;
  endfunction

  function automatic step_t deliver(step_t s, event_t ev, cfg_t cfg);
    step_t r;
    logic  fault;
    fault = (ev == EV_ESTOP) || (ev == EV_ERROR);
    r = s;
    case (s.st.cur)
      MODE_IDLE: begin
        if (ev == EV_START)       r = go_to(s, MODE_MOW);
        else if (ev == EV_MANUAL) r = go_to(s, MODE_MANUAL);
        else if (ev == EV_RETURN) r = go_to(s, MODE_RETURN);
      end
      MODE_MOW: begin
        if (ev == EV_STOP)                          r = go_to(s, MODE_IDLE);
        else if (ev == EV_LOWBAT || ev == EV_RETURN) r = go_to(s, MODE_RETURN);
        else if (ev == EV_OBST)                     r = go_to(s, MODE_OBST);
        else if (ev == EV_BORDER)                   r = go_to(s, MODE_BORDER);
      end
      MODE_MANUAL: begin
        if (ev == EV_RETURN) r = go_to(s, MODE_RETURN);
      end
      MODE_RETURN: begin
        if (ev == EV_DOCKED)      r = go_to(s, MODE_CHARGE);
        else if (ev == EV_MANUAL) r = go_to(s, MODE_MANUAL);
      end
      MODE_CHARGE: begin
        if (ev == EV_CHARGED)     r = go_to(s, MODE_IDLE);
        else if (ev == EV_MANUAL) r = go_to(s, MODE_MANUAL);
      end
      MODE_EMERG: begin
        if (ev == EV_CLEARED)
          r = go_to(s, (s.st.prior != MODE_EMERG) ? s.st.prior : MODE_IDLE);
      end
      MODE_BORDER: begin
        if (!fault && over(s.st.elapsed, cfg.bord_timeout)) r = go_to(s, s.st.prior);
      end
      MODE_OBST: begin
        if (!fault && over(s.st.elapsed, cfg.obst_timeout)) r = go_to(s, s.st.prior);
      end
      default: begin
        r = s;
      end
    endcase
    if (fault) r = go_to(r, MODE_EMERG);
    return r;
  endfunction

endpackage

>>> rtl/core/mower_mode_supervisor_unit.sv
// ============================================================================
// Mower mode supervisor
// Keeps the mower mode, applies event tables and millisecond timeouts, and
// reports the mode and actuator enables for every request.
// ============================================================================
// Each request (an event or a one-millisecond tick) is taken while input ready
// is high, and a new one may follow in every cycle while ready stays high. The
// whole update is one pass of logic from the mode state registers into a
// two-entry result buffer (main and skid slot), so input ready drops only when
// both result slots are full. Configuration writes complete in the cycle they
// are presented; reset needs no clearing pass.
module mower_mode_supervisor_unit import mms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [3:0]           event_code_i,
  input  logic                 nav_busy_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           mode_now_o,
  output logic                 mode_changed_o,
  output logic                 relay_enable_o,
  output logic                 blade_enable_o,
  output logic                 nav_random_o
);

  cfg_t      cfg;
  sv_state_t state_q, state_d, state_next;
  result_t   result, out_data;
  logic      accept;

  mms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mms_next_state u_next (
    .state_i      (state_q),
    .cfg_i        (cfg),
    .req_type_i   (req_type_i),
    .event_code_i (event_code_i),
    .nav_busy_i   (nav_busy_i),
    .state_o      (state_next),
    .result_o     (result)
  );

  assign accept  = in_valid_i && in_ready_o;
  assign state_d = accept ? state_next : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  mms_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign mode_now_o     = out_data.mode_now;
  assign mode_changed_o = out_data.mode_changed;
  assign relay_enable_o = out_data.relay_enable;
  assign blade_enable_o = out_data.blade_enable;
  assign nav_random_o   = out_data.nav_random;

  a_change_clears_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && result.mode_changed) |=> (state_q.elapsed == '0))
    else $error("mode change did not clear the elapsed time");

  a_tick_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i && !result.mode_changed && state_q.elapsed != '1)
    |=> (state_q.elapsed == TIME_WIDTH'($past(state_q.elapsed) + 1'b1)))
    else $error("tick without a mode change did not advance the elapsed time");

  a_safe_modes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.cur == MODE_EMERG || state_q.cur == MODE_IDLE)
    |-> (!state_q.blade && !state_q.wander))
    else $error("blade or wander flag set in idle or emergency mode");

endmodule

>>> rtl/core/mms_cfg_regs.sv
// ============================================================================
// Mower mode supervisor configuration registers
// Holds the mowing time limit and the two recovery timeouts.
// ============================================================================
module mms_cfg_regs import mms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_idx_t  cfg_index_i,
  input  cfg_word_t cfg_data_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MOW_LIMIT:    cfg_d.mow_limit    = cfg_data_i;
        CFG_OBST_TIMEOUT: cfg_d.obst_timeout = cfg_data_i;
        CFG_BORD_TIMEOUT: cfg_d.bord_timeout = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mow_limit    <= MOW_LIMIT_RESET;
      cfg_q.obst_timeout <= OBST_TIMEOUT_RESET;
      cfg_q.bord_timeout <= BORD_TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/mms_next_state.sv
// ============================================================================
// Mower mode supervisor next-state logic
// Evaluates one event or tick request against the current state.
// ============================================================================
module mms_next_state import mms_pkg::*; (
  input  sv_state_t state_i,
  input  cfg_t      cfg_i,
  input  logic      req_type_i,
  input  event_t    event_code_i,
  input  logic      nav_busy_i,
  output sv_state_t state_o,
  output result_t   result_o
);

  step_t s0;
  step_t s1;
  step_t s2;
  step_t s3;

  always_comb begin
    s0.st      = state_i;
    s0.changed = 1'b0;
    s1 = s0;
    s2 = s0;
    s3 = s0;
    if (!req_type_i) begin
      s3 = deliver(s0, event_code_i, cfg_i);
    end else begin
      if (s0.st.elapsed != '1) s1.st.elapsed = TIME_WIDTH'(s0.st.elapsed + 1'b1);
      // Navigation finished its manoeuvre: try the recovery return first.
      if ((s1.st.cur == MODE_BORDER || s1.st.cur == MODE_OBST) && !nav_busy_i)
        s2 = deliver(s1, EV_START, cfg_i);
      else
        s2 = s1;
      s3 = s2;
      case (s2.st.cur)
        MODE_MOW: begin
          if (over(s2.st.elapsed, cfg_i.mow_limit)) s3 = deliver(s2, EV_LOWBAT, cfg_i);
        end
        MODE_OBST: begin
          if (over(s2.st.elapsed, cfg_i.obst_timeout)) s3 = go_to(s2, MODE_MOW);
        end
        MODE_BORDER: begin
          if (over(s2.st.elapsed, cfg_i.bord_timeout)) s3 = go_to(s2, MODE_MOW);
        end
        default: begin
          s3 = s2;
        end
      endcase
    end
  end

  assign state_o = s3.st;

  always_comb begin
    result_o.mode_now     = s3.st.cur;
    result_o.mode_changed = s3.changed;
    result_o.relay_enable = s3.st.cur inside {MODE_MOW, MODE_MANUAL, MODE_RETURN,
                                              MODE_BORDER, MODE_OBST};
    result_o.blade_enable = s3.st.blade;
    result_o.nav_random   = s3.st.wander;
  end

endmodule

>>> rtl/core/mms_out_buf.sv
// ============================================================================
// Mower mode supervisor result buffer
// Two-entry output register with a skid slot so requests are still taken while
// the consumer stalls, until both slots are full.
// ============================================================================
module mms_out_buf import mms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = main_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        if (push_i) main_d = data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_d       = data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot holds a result while the main slot is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (main_valid_q && !skid_valid_q))
    else $error("skid slot did not move into the main slot");

endmodule
